// ----- hdl/bbcm_pkg.sv -----
// ----------------------------------------------------------------------------
// Buffer cache manager package
// Operation and status codes, field widths, tag entry and sequencer types.
// ----------------------------------------------------------------------------
package bbcm_pkg;

  // Field widths
  localparam int OP_W   = 2;
  localparam int DEV_W  = 8;
  localparam int BLK_W  = 24;
  localparam int SLOT_W = 6;
  localparam int CNT_W  = 8;
  localparam int STS_W  = 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_GET     = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  // Result status codes
  localparam logic [STS_W-1:0] STS_HIT      = 3'd0;
  localparam logic [STS_W-1:0] STS_MISS     = 3'd1;
  localparam logic [STS_W-1:0] STS_NOTFOUND = 3'd2;
  localparam logic [STS_W-1:0] STS_NOFREE   = 3'd3;
  localparam logic [STS_W-1:0] STS_IGNORED  = 3'd4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // One tag memory word
  typedef struct packed {
    logic             valid;
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
  } tag_t;

  // One result beat
  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  cnt;
  } result_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_REL,
    S_WALK0,
    S_WALK,
    S_LINK1,
    S_LINK2,
    S_LINK3,
    S_LINK4,
    S_LINK5,
    S_DONE
  } state_t;

endpackage

// ----- hdl/block_buffer_cache_manager_top.sv -----
// ----------------------------------------------------------------------------
// Block buffer cache manager
// Tag manager for a disk block buffer cache with an LRU replacement ring.
//
// After reset the block sweeps its memories to load the reset tags, counts and
// ring links, and stalls its input meanwhile. It then works on one beat at a
// time. Get and lookup scan the tag memory one entry per cycle. A get miss then
// walks the ring one link per cycle through the next-pointer memory and relinks
// the victim through states S_LINK1 to S_LINK5. A finished result sits in the
// output register while the next beat is accepted.
// ----------------------------------------------------------------------------
module block_buffer_cache_manager_top
  import bbcm_pkg::*;
#(
  parameter int NUM_ENTRIES = 64,
  localparam int IDX_W = $clog2(NUM_ENTRIES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_op,
  input  logic [DEV_W-1:0]  in_device,
  input  logic [BLK_W-1:0]  in_block_number,
  input  logic [SLOT_W-1:0] in_entry_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STS_W-1:0]  out_status,
  output logic [SLOT_W-1:0] out_slot,
  output logic [CNT_W-1:0]  out_ref_count
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);
  localparam logic [IDX_W:0]   SCAN_END = (IDX_W + 1)'(NUM_ENTRIES);
  localparam int               TAG_W    = $bits(tag_t);

  // Widen an entry index to the slot field
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] i);
    logic [IDX_W+SLOT_W-1:0] w;
    w = {{SLOT_W{1'b0}}, i};
    return w[SLOT_W-1:0];
  endfunction

  // Check a release index against the entry count
  function automatic logic idx_ok(input logic [SLOT_W-1:0] s);
    logic [IDX_W+SLOT_W-1:0] w;
    w = {{IDX_W{1'b0}}, s};
    return w < (IDX_W + SLOT_W)'(NUM_ENTRIES);
  endfunction

  // Narrow a release index to an entry index
  function automatic logic [IDX_W-1:0] to_idx(input logic [SLOT_W-1:0] s);
    logic [IDX_W+SLOT_W-1:0] w;
    w = {{IDX_W{1'b0}}, s};
    return w[IDX_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic [IDX_W:0]    scan_r, scan_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic [IDX_W-1:0]  e_r, e_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [IDX_W-1:0]  n_r, n_nxt;
  logic [IDX_W-1:0]  t_r, t_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [OP_W-1:0]   op_r;
  logic [DEV_W-1:0]  dev_r;
  logic [BLK_W-1:0]  blk_r;
  logic [SLOT_W-1:0] eidx_r;
  result_t           res_r, res_nxt;
  logic              out_valid_r;
  result_t           out_r;

  logic in_acc;
  logic out_free;
  logic match;

  // Memory ports
  logic             tag_we;
  logic [IDX_W-1:0] tag_waddr, tag_raddr;
  tag_t             tag_wdata, tag_rd;
  logic [TAG_W-1:0] tag_rbits;
  logic             cnt_we;
  logic [IDX_W-1:0] cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0] cnt_wdata, cnt_rd;
  logic             nxt_we;
  logic [IDX_W-1:0] nxt_waddr, nxt_raddr, nxt_wdata, nxt_rd;
  logic             prv_we;
  logic [IDX_W-1:0] prv_waddr, prv_raddr, prv_wdata, prv_rd;

  bbcm_ram #(.WIDTH(TAG_W), .DEPTH(NUM_ENTRIES)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rbits)
  );
  assign tag_rd = tag_t'(tag_rbits);

  bbcm_ram #(.WIDTH(CNT_W), .DEPTH(NUM_ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rd)
  );

  bbcm_ram #(.WIDTH(IDX_W), .DEPTH(NUM_ENTRIES)) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (nxt_raddr),
    .rdata (nxt_rd)
  );

  bbcm_ram #(.WIDTH(IDX_W), .DEPTH(NUM_ENTRIES)) u_prev_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .raddr (prv_raddr),
    .rdata (prv_rd)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Shared tag compare: entry read last cycle against the request
  assign match = chk_vld_r && tag_rd.valid && (tag_rd.dev == dev_r) && (tag_rd.blk == blk_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == LAST_IDX) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_GET, OP_LOOKUP: state_nxt = S_SCAN;
            OP_RELEASE:        state_nxt = idx_ok(in_entry_index) ? S_REL : S_DONE;
            default:           state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (match) begin
          state_nxt = S_DONE;
        end else if (scan_r == SCAN_END) begin
          state_nxt = (op_r == OP_GET) ? S_WALK0 : S_DONE;
        end
      end
      S_REL:   state_nxt = S_DONE;
      S_WALK0: state_nxt = S_WALK;
      S_WALK: begin
        if (cnt_rd == '0) begin
          state_nxt = S_LINK1;
        end else if (k_r == LAST_IDX) begin
          state_nxt = S_DONE;
        end
      end
      S_LINK1: state_nxt = S_LINK2;
      S_LINK2: state_nxt = S_LINK3;
      S_LINK3: state_nxt = S_LINK4;
      S_LINK4: state_nxt = S_LINK5;
      S_LINK5: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Memory controls and datapath next values
  always_comb begin
    clr_nxt     = clr_r;
    scan_nxt    = scan_r;
    chk_vld_nxt = 1'b0;
    chk_idx_nxt = chk_idx_r;
    e_nxt       = e_r;
    k_nxt       = k_r;
    n_nxt       = n_r;
    t_nxt       = t_r;
    head_nxt    = head_r;
    res_nxt     = res_r;

    tag_we    = 1'b0;
    tag_waddr = e_r;
    tag_wdata = '{valid: 1'b1, dev: dev_r, blk: blk_r};
    tag_raddr = scan_r[IDX_W-1:0];
    cnt_we    = 1'b0;
    cnt_waddr = e_r;
    cnt_wdata = CNT_W'(1);
    cnt_raddr = scan_r[IDX_W-1:0];
    nxt_we    = 1'b0;
    nxt_waddr = e_r;
    nxt_wdata = head_r;
    nxt_raddr = e_r;
    prv_we    = 1'b0;
    prv_waddr = e_r;
    prv_wdata = t_r;
    prv_raddr = e_r;

    case (state_r)
      // Load reset tags, counts and ring links, one entry a cycle
      S_CLEAR: begin
        clr_nxt   = clr_r + IDX_W'(1);
        tag_we    = 1'b1;
        tag_waddr = clr_r;
        tag_wdata = '{valid: 1'b0, dev: '0, blk: '0};
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
        nxt_we    = 1'b1;
        nxt_waddr = clr_r;
        nxt_wdata = (clr_r == LAST_IDX) ? '0 : clr_r + IDX_W'(1);
        prv_we    = 1'b1;
        prv_waddr = clr_r;
        prv_wdata = (clr_r == '0) ? LAST_IDX : clr_r - IDX_W'(1);
      end
      // Start a scan or read the count to release
      S_IDLE: begin
        scan_nxt  = '0;
        cnt_raddr = to_idx(in_entry_index);
        if (in_acc) begin
          if (in_op == OP_RELEASE) begin
            res_nxt = '{status: STS_IGNORED, slot: in_entry_index, cnt: '0};
          end else begin
            res_nxt = '{status: STS_IGNORED, slot: '0, cnt: '0};
          end
        end
      end
      // Issue one tag read a cycle, compare the one read last cycle
      S_SCAN: begin
        if (scan_r != SCAN_END) begin
          scan_nxt    = scan_r + (IDX_W + 1)'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_r[IDX_W-1:0];
        end
        if (match) begin
          if (op_r == OP_LOOKUP) begin
            cnt_we    = 1'b1;
            cnt_waddr = chk_idx_r;
            cnt_wdata = (cnt_rd == CNT_MAX) ? CNT_MAX : cnt_rd + CNT_W'(1);
            res_nxt   = '{status: STS_HIT, slot: to_slot(chk_idx_r), cnt: cnt_wdata};
          end else begin
            res_nxt = '{status: STS_HIT, slot: to_slot(chk_idx_r), cnt: cnt_rd};
          end
        end else if (scan_r == SCAN_END) begin
          res_nxt = '{status: STS_NOTFOUND, slot: '0, cnt: '0};
        end
      end
      // Drop one reference from a nonzero count
      S_REL: begin
        if (cnt_rd == '0) begin
          res_nxt = '{status: STS_IGNORED, slot: eidx_r, cnt: '0};
        end else begin
          cnt_we    = 1'b1;
          cnt_waddr = to_idx(eidx_r);
          cnt_wdata = cnt_rd - CNT_W'(1);
          res_nxt   = '{status: STS_HIT, slot: eidx_r, cnt: cnt_wdata};
        end
      end
      // Read the ring from entry zero
      S_WALK0: begin
        e_nxt     = '0;
        k_nxt     = '0;
        cnt_raddr = '0;
        nxt_raddr = '0;
      end
      // Follow one link a cycle until a free entry or the end of the ring
      S_WALK: begin
        cnt_raddr = nxt_rd;
        nxt_raddr = nxt_rd;
        if (cnt_rd == '0) begin
          n_nxt = nxt_rd;
        end else if (k_r == LAST_IDX) begin
          res_nxt = '{status: STS_NOFREE, slot: '0, cnt: '0};
        end else begin
          e_nxt = nxt_rd;
          k_nxt = k_r + IDX_W'(1);
        end
      end
      // Retag the victim, set its count, read its back link
      S_LINK1: begin
        tag_we    = 1'b1;
        cnt_we    = 1'b1;
        prv_raddr = e_r;
      end
      // Unlink the victim
      S_LINK2: begin
        nxt_we    = 1'b1;
        nxt_waddr = prv_rd;
        nxt_wdata = n_r;
        prv_we    = 1'b1;
        prv_waddr = n_r;
        prv_wdata = prv_rd;
        if (head_r == e_r) head_nxt = n_r;
      end
      // Read the tail in front of the head
      S_LINK3: begin
        prv_raddr = head_r;
      end
      // Point the victim at head and tail
      S_LINK4: begin
        t_nxt     = prv_rd;
        nxt_we    = 1'b1;
        nxt_waddr = e_r;
        nxt_wdata = head_r;
        prv_we    = 1'b1;
        prv_waddr = e_r;
        prv_wdata = prv_rd;
      end
      // Point tail and head at the victim
      S_LINK5: begin
        nxt_we    = 1'b1;
        nxt_waddr = t_r;
        nxt_wdata = e_r;
        prv_we    = 1'b1;
        prv_waddr = head_r;
        prv_wdata = e_r;
        res_nxt   = '{status: STS_MISS, slot: to_slot(e_r), cnt: CNT_W'(1)};
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      head_r      <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      head_r    <= head_nxt;
      chk_vld_r <= chk_vld_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_r    <= scan_nxt;
    chk_idx_r <= chk_idx_nxt;
    e_r       <= e_nxt;
    k_r       <= k_nxt;
    n_r       <= n_nxt;
    t_r       <= t_nxt;
    res_r     <= res_nxt;
    if (in_acc) begin
      op_r   <= in_op;
      dev_r  <= in_device;
      blk_r  <= in_block_number;
      eidx_r <= in_entry_index;
    end
    if (state_r == S_DONE && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_r.status;
  assign out_slot      = out_r.slot;
  assign out_ref_count = out_r.cnt;

endmodule

// ----- hdl/bbcm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bbcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/bbcm_checker.sv -----
// ----------------------------------------------------------------------------
// Buffer cache manager port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
module bbcm_checker
  import bbcm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [STS_W-1:0]  out_status,
  input logic [SLOT_W-1:0] out_slot,
  input logic [CNT_W-1:0]  out_ref_count
);

  // Hold a stalled beat
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_status) && $stable(out_slot)
      && $stable(out_ref_count))
    else $error("result payload changed while stalled");

  // Status stays within its codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= STS_IGNORED)
    else $error("undefined status code");

  // A newly assigned entry holds one reference
  a_miss_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_MISS |-> out_ref_count == CNT_W'(1))
    else $error("miss without a single reference");

  // Failed lookups and full caches report nothing
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STS_NOTFOUND || out_status == STS_NOFREE)
      |-> out_slot == '0 && out_ref_count == '0)
    else $error("failed search carries a slot or count");

endmodule

bind block_buffer_cache_manager_top bbcm_checker u_bbcm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_slot      (out_slot),
  .out_ref_count (out_ref_count)
);
